FILE: rtl/frame_parser_xor_check_core_assert.svh
// Assertion macros used by the frame parser readout.
`ifndef FRAME_PARSER_XOR_CHECK_CORE_ASSERT_SVH
`define FRAME_PARSER_XOR_CHECK_CORE_ASSERT_SVH

// Check a same-cycle implication, skipped during reset.
`define FPXC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication in the following cycle, skipped during reset.
`define FPXC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fpxc_pkg.sv
// Types and constants of the frame parser with XOR check.
`default_nettype none

package fpxc_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int LEN_W       = 7;
   localparam int CSR_IDX_W   = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_CMD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_RPLY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC2      = 2'd2;

   // Reset values of the configuration registers
   localparam logic [7:0] START_CMD_RST  = 8'hAA;
   localparam logic [7:0] START_RPLY_RST = 8'hAB;
   localparam logic [7:0] SYNC2_RST      = 8'h55;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_SYNC  = 3'd1,
      PH_CHAN  = 3'd2,
      PH_LENH  = 3'd3,
      PH_LENL  = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHECK = 3'd6
   } phase_type;

   // Payload store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // Finished frame handed to readout
   typedef struct packed {
      logic             valid;
      logic [7:0]       start;
      logic [7:0]       channel;
      logic [LEN_W-1:0] length;
      logic             ok;
      logic             empty;
   } launch_type;

endpackage

`default_nettype wire

FILE: rtl/frame_parser_xor_check_core.sv
// Top level of the framed byte parser with XOR check byte.
//
// Parsing takes one received byte per cycle unless held off: start marker,
// second sync byte, channel, 16-bit big-endian length, payload and check
// byte. Payload bytes go into a 64-entry store with one write and one
// registered read port. When the check byte is taken, the frame's results are
// read out of the store one per cycle unless stalled (the single read port
// sets this), so a frame of N payload bytes gives N results (one for an empty
// frame) and input is held off during readout. Frames longer than MAX_DATA
// are dropped without results. Configuration writes are taken in every cycle.
`default_nettype none

module frame_parser_xor_check_core #(
   parameter int MAX_DATA = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fpxc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [7:0]                        csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_rx_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_frame_start,
   output logic [7:0]                             rsp_channel,
   output logic [fpxc_pkg::LEN_W-1:0]             rsp_payload_length,
   output logic [7:0]                             rsp_payload_byte,
   output logic [fpxc_pkg::ADDR_W-1:0]            rsp_byte_index,
   output logic                                   rsp_has_payload,
   output logic                                   rsp_check_ok,
   output logic                                   rsp_last
);

   localparam logic [7:0] MaxLen = 8'(MAX_DATA);

   // configuration registers
   logic [7:0] start_cmd_ff, start_rply_ff, sync2_ff;

   // parser state
   fpxc_pkg::phase_type        phase_ff, phase_in;
   logic [7:0]                 start_ff, start_in;
   logic [7:0]                 chan_ff, chan_in;
   logic                       len_hi_ff, len_hi_in;
   logic [fpxc_pkg::LEN_W-1:0] len_ff, len_in;
   logic [fpxc_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]                 xor_ff, xor_in;

   fpxc_pkg::store_wr_type wr;
   fpxc_pkg::launch_type   launch;
   logic                   busy;
   logic                   take;
   logic                   is_start;
   logic [fpxc_pkg::LEN_W-1:0] fill_next;

   assign csr_ready = 1'b1;
   assign req_ready = !busy;
   assign take      = req_valid && req_ready;
   assign is_start  = (req_rx_byte == start_cmd_ff) || (req_rx_byte == start_rply_ff);
   assign fill_next = fpxc_pkg::LEN_W'(fill_ff + 7'd1);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_cmd_ff  <= fpxc_pkg::START_CMD_RST;
         start_rply_ff <= fpxc_pkg::START_RPLY_RST;
         sync2_ff      <= fpxc_pkg::SYNC2_RST;
      end else if (csr_valid) begin
         case (csr_index)
            fpxc_pkg::CSR_START_CMD:  start_cmd_ff  <= csr_data;
            fpxc_pkg::CSR_START_RPLY: start_rply_ff <= csr_data;
            fpxc_pkg::CSR_SYNC2:      sync2_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance the parse phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            fpxc_pkg::PH_SYNC: begin
               if (req_rx_byte == sync2_ff) begin
                  phase_in = fpxc_pkg::PH_CHAN;
               end else if (!is_start) begin
                  phase_in = fpxc_pkg::PH_START;
               end
            end
            fpxc_pkg::PH_CHAN:  phase_in = fpxc_pkg::PH_LENH;
            fpxc_pkg::PH_LENH:  phase_in = fpxc_pkg::PH_LENL;
            fpxc_pkg::PH_LENL: begin
               if (len_hi_ff || (req_rx_byte > MaxLen)) begin
                  phase_in = fpxc_pkg::PH_START;
               end else if (req_rx_byte == 8'h00) begin
                  phase_in = fpxc_pkg::PH_CHECK;
               end else begin
                  phase_in = fpxc_pkg::PH_DATA;
               end
            end
            fpxc_pkg::PH_DATA: begin
               if (fill_next >= len_ff) begin
                  phase_in = fpxc_pkg::PH_CHECK;
               end
            end
            fpxc_pkg::PH_CHECK: phase_in = fpxc_pkg::PH_START;
            default: begin
               phase_in = is_start ? fpxc_pkg::PH_SYNC : fpxc_pkg::PH_START;
            end
         endcase
      end
   end

   // Drive store writes, the frame launch and the held header fields
   always_comb begin
      start_in       = start_ff;
      chan_in        = chan_ff;
      len_hi_in      = len_hi_ff;
      len_in         = len_ff;
      fill_in        = fill_ff;
      xor_in         = xor_ff;
      wr.en          = 1'b0;
      wr.addr        = fill_ff[fpxc_pkg::ADDR_W-1:0];
      wr.data        = req_rx_byte;
      launch.valid   = 1'b0;
      launch.start   = start_ff;
      launch.channel = chan_ff;
      launch.length  = len_ff;
      launch.ok      = (req_rx_byte == xor_ff);
      launch.empty   = (len_ff == '0);
      if (take) begin
         case (phase_ff)
            fpxc_pkg::PH_SYNC: begin
               if ((req_rx_byte != sync2_ff) && is_start) begin
                  start_in = req_rx_byte;
               end
            end
            fpxc_pkg::PH_CHAN: begin
               chan_in = req_rx_byte;
               xor_in  = req_rx_byte;
            end
            fpxc_pkg::PH_LENH: begin
               len_hi_in = (req_rx_byte != 8'h00);
               xor_in    = xor_ff ^ req_rx_byte;
            end
            fpxc_pkg::PH_LENL: begin
               len_in  = req_rx_byte[fpxc_pkg::LEN_W-1:0];
               xor_in  = xor_ff ^ req_rx_byte;
               fill_in = '0;
            end
            fpxc_pkg::PH_DATA: begin
               wr.en   = 1'b1;
               xor_in  = xor_ff ^ req_rx_byte;
               fill_in = fill_next;
            end
            fpxc_pkg::PH_CHECK: launch.valid = 1'b1;
            default: begin
               if (is_start) begin
                  start_in = req_rx_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fpxc_pkg::PH_START;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Header and running check need no reset: each is set before use
   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      chan_ff   <= chan_in;
      len_hi_ff <= len_hi_in;
      len_ff    <= len_in;
      fill_ff   <= fill_in;
      xor_ff    <= xor_in;
   end

   fpxc_readout u_readout (
      .clock              (clock),
      .reset              (reset),
      .wr                 (wr),
      .launch             (launch),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_channel        (rsp_channel),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_check_ok       (rsp_check_ok),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

FILE: rtl/fpxc_readout.sv
// Payload store and result readout sequencer of the frame parser.
`default_nettype none

`include "frame_parser_xor_check_core_assert.svh"

module fpxc_readout (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fpxc_pkg::store_wr_type        wr,
   input  wire fpxc_pkg::launch_type          launch,
   output logic                               busy,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_frame_start,
   output logic [7:0]                         rsp_channel,
   output logic [fpxc_pkg::LEN_W-1:0]         rsp_payload_length,
   output logic [7:0]                         rsp_payload_byte,
   output logic [fpxc_pkg::ADDR_W-1:0]        rsp_byte_index,
   output logic                               rsp_has_payload,
   output logic                               rsp_check_ok,
   output logic                               rsp_last
);

   logic [7:0] store_mem [fpxc_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // control state
   logic                      busy_ff, busy_in;
   logic                      valid_ff, valid_in;
   logic [fpxc_pkg::LEN_W-1:0] next_ff, next_in;

   // frame header held for the readout
   logic [7:0]                 hdr_start_ff, hdr_chan_ff;
   logic [fpxc_pkg::LEN_W-1:0] hdr_len_ff;
   logic                       hdr_ok_ff, hdr_empty_ff;

   // output word registers
   logic [7:0]                  out_start_ff, out_chan_ff;
   logic [fpxc_pkg::LEN_W-1:0]  out_len_ff;
   logic [fpxc_pkg::ADDR_W-1:0] out_idx_ff;
   logic                        out_has_ff, out_ok_ff, out_last_ff;

   logic issue, issue_last;

   // Issue the next word when the output slot is free or being taken
   assign issue      = busy_ff && (!valid_ff || rsp_ready);
   assign issue_last = hdr_empty_ff ||
                       (fpxc_pkg::LEN_W'(next_ff + 7'd1) == hdr_len_ff);

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      next_in  = next_ff;
      if (issue) begin
         valid_in = 1'b1;
         next_in  = fpxc_pkg::LEN_W'(next_ff + 7'd1);
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
      // Start a new frame; the last word of the previous one may still be draining
      if (launch.valid) begin
         busy_in = 1'b1;
         next_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         next_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         next_ff  <= next_in;
      end
   end

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (issue && !hdr_empty_ff) begin
         rd_data_ff <= store_mem[next_ff[fpxc_pkg::ADDR_W-1:0]];
      end
   end

   // Capture the header at launch, copy it into each output word
   always_ff @(posedge clock) begin
      if (launch.valid) begin
         hdr_start_ff <= launch.start;
         hdr_chan_ff  <= launch.channel;
         hdr_len_ff   <= launch.length;
         hdr_ok_ff    <= launch.ok;
         hdr_empty_ff <= launch.empty;
      end
      if (issue) begin
         out_start_ff <= hdr_start_ff;
         out_chan_ff  <= hdr_chan_ff;
         out_len_ff   <= hdr_len_ff;
         out_idx_ff   <= hdr_empty_ff ? '0 : next_ff[fpxc_pkg::ADDR_W-1:0];
         out_has_ff   <= !hdr_empty_ff;
         out_ok_ff    <= hdr_ok_ff;
         out_last_ff  <= issue_last;
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_frame_start    = out_start_ff;
   assign rsp_channel        = out_chan_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_payload_byte   = out_has_ff ? rd_data_ff : 8'h00;
   assign rsp_byte_index     = out_idx_ff;
   assign rsp_has_payload    = out_has_ff;
   assign rsp_check_ok       = out_ok_ff;
   assign rsp_last           = out_last_ff;

   `FPXC_ASSERT_NOW(a_no_write_busy, wr.en, !busy_ff, "store written during readout")
   `FPXC_ASSERT_NOW(a_launch_idle, launch.valid, !busy_ff, "frame launched during readout")
   `FPXC_ASSERT_NEXT(a_last_ends, issue && issue_last, !busy_ff, "readout busy after last word")
   `FPXC_ASSERT_NOW(a_empty_last, valid_ff && !out_has_ff, out_last_ff,
                    "empty frame word without last")

endmodule

`default_nettype wire
